[rtl/mmh64b_pkg.sv]
package mmh64b_pkg;

    // Mixing multiplier and shift amounts
    localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;
    localparam int          MIX_SHIFT  = 24;
    localparam logic [31:0] SEED_RESET = 32'hEE6B27EB;
    localparam int          FIN_SH1    = 18;
    localparam int          FIN_SH2    = 22;
    localparam int          FIN_SH3    = 17;
    localparam int          FIN_SH4    = 19;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_K1,
        S_K2,
        S_FOLD,
        S_TAIL,
        S_FIN1,
        S_FIN2,
        S_FIN3,
        S_FIN4,
        S_EMIT
    } mmh_state_t;

    // Keep the valid low bytes of a partial word
    function automatic logic [31:0] tail_mask(input logic [2:0] nbytes);
        logic [31:0] m;
        begin
            unique case (nbytes)
                3'd1:    m = 32'h0000_00FF;
                3'd2:    m = 32'h0000_FFFF;
                3'd3:    m = 32'h00FF_FFFF;
                default: m = 32'h0000_0000;
            endcase
            return m;
        end
    endfunction

endpackage

[rtl/murmur_hash_64b_top.sv]
// MurmurHash64B over a message delivered as little-endian 32-bit words.
// Input channel: in_valid/in_stall with data_word, word_bytes, is_first,
// is_last and message_length (length read only on the first word). A
// transaction is taken when in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall with hash_value, one transaction per
// message, emitted after the word that carries is_last.
// Seed: hash_seed is written when seed_we is high; write only while idle.
// Steps: one 32x32 multiplier is shared by all steps. A whole word passes
// through accept, two key multiplies and a lane multiply, a 1..3 byte word
// through accept and the tail multiply, an empty word through accept only.
// The last word adds the finalization steps S_FIN1..S_FIN4 and the emit
// step that loads the output register.
// The input is stalled while a word is in work; the next word may be
// taken while a hash still waits.
// If the receiver stalls, the hash holds in its output register; a
// following hash waits in the emit step until that register frees up.
// Reset: lanes clear, seed returns to 0xEE6B27EB, no hash is pending.
module murmur_hash_64b_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_we,
    input  logic [31:0] hash_seed,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  word_bytes,
    input  logic        is_first,
    input  logic        is_last,
    input  logic [30:0] message_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] hash_value
);
    import mmh64b_pkg::*;

    mmh_state_t  state_reg, state_next;
    logic [31:0] seed_reg;
    logic [31:0] lane_one_reg, lane_one_next;
    logic [31:0] lane_two_reg, lane_two_next;
    logic        lane_sel_reg, lane_sel_next;
    logic [31:0] word_reg, word_next;
    logic [31:0] key_reg, key_next;
    logic [2:0]  nbytes_reg, nbytes_next;
    logic        last_reg, last_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] hash_reg, hash_next;
    logic [31:0] mul_a;
    logic [31:0] mul_res;
    logic        in_fire;
    logic        out_free;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_fire    = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    // Shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            S_K1:    mul_a = word_reg;
            S_K2:    mul_a = key_reg;
            S_FOLD:  mul_a = lane_sel_reg ? lane_two_reg : lane_one_reg;
            S_TAIL:  mul_a = lane_two_reg ^ (word_reg & tail_mask(nbytes_reg));
            S_FIN1:  mul_a = lane_one_reg ^ (lane_two_reg >> FIN_SH1);
            S_FIN2:  mul_a = lane_two_reg ^ (lane_one_reg >> FIN_SH2);
            S_FIN3:  mul_a = lane_one_reg ^ (lane_two_reg >> FIN_SH3);
            S_FIN4:  mul_a = lane_two_reg ^ (lane_one_reg >> FIN_SH4);
            default: mul_a = word_reg;
        endcase
    end

    // Low half of the product is all the hash needs
    assign mul_res = mul_a * MIX_MUL;

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        lane_one_next  = lane_one_reg;
        lane_two_next  = lane_two_reg;
        lane_sel_next  = lane_sel_reg;
        word_next      = word_reg;
        key_next       = key_reg;
        nbytes_next    = nbytes_reg;
        last_next      = last_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    word_next   = data_word;
                    nbytes_next = word_bytes;
                    last_next   = is_last;
                    if (is_first)
                    begin
                        lane_one_next = seed_reg ^ {1'b0, message_length};
                        lane_two_next = 32'd0;
                        lane_sel_next = 1'b0;
                    end
                    priority if (word_bytes[2])
                        state_next = S_K1;
                    else if (word_bytes != 3'd0)
                        state_next = S_TAIL;
                    else if (is_last)
                        state_next = S_FIN1;
                    else
                        state_next = S_IDLE;
                end
            end
            S_K1:
            begin
                key_next   = mul_res ^ (mul_res >> MIX_SHIFT);
                state_next = S_K2;
            end
            S_K2:
            begin
                key_next   = mul_res;
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                if (lane_sel_reg)
                    lane_two_next = mul_res ^ key_reg;
                else
                    lane_one_next = mul_res ^ key_reg;
                lane_sel_next = !lane_sel_reg;
                state_next    = last_reg ? S_FIN1 : S_IDLE;
            end
            S_TAIL:
            begin
                lane_two_next = mul_res;
                state_next    = last_reg ? S_FIN1 : S_IDLE;
            end
            S_FIN1:
            begin
                lane_one_next = mul_res;
                state_next    = S_FIN2;
            end
            S_FIN2:
            begin
                lane_two_next = mul_res;
                state_next    = S_FIN3;
            end
            S_FIN3:
            begin
                lane_one_next = mul_res;
                state_next    = S_FIN4;
            end
            S_FIN4:
            begin
                lane_two_next = mul_res;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                // wait for the output register to free up
                if (out_free)
                begin
                    hash_next      = {lane_one_reg, lane_two_reg};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and lane state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seed_reg      <= SEED_RESET;
            lane_one_reg  <= 32'd0;
            lane_two_reg  <= 32'd0;
            lane_sel_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lane_one_reg  <= lane_one_next;
            lane_two_reg  <= lane_two_next;
            lane_sel_reg  <= lane_sel_next;
            out_valid_reg <= out_valid_next;
            if (seed_we)
                seed_reg <= hash_seed;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        key_reg    <= key_next;
        nbytes_reg <= nbytes_next;
        last_reg   <= last_next;
        hash_reg   <= hash_next;
    end

    // Lane selector flips on every whole-word fold
    a_fold_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FOLD |=> lane_sel_reg != $past(lane_sel_reg))
        else $error("lane selector did not toggle after fold");

    // A first word restarts lane two and the selector
    a_first_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && is_first |=> lane_two_reg == 32'd0 && !lane_sel_reg)
        else $error("first word did not restart the lanes");

    // Emit loads the output register and frees the input
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && out_free |=> out_valid_reg && state_reg == S_IDLE)
        else $error("hash not loaded on emit");

    // A whole word goes to the key multiply next
    a_word_path: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && word_bytes[2] |=> state_reg == S_K1)
        else $error("whole word did not start key mix");

endmodule

[tb/murmur_hash_64b_top_test.sv]
module murmur_hash_64b_top_test;

    import mmh64b_pkg::*;

    // One input word as offered on the input channel
    typedef struct {
        bit [31:0] word;
        bit [2:0]  nbytes;
        bit        first;
        bit        last;
        bit [30:0] len;
    } hash_word_t;

    // Tracks the two hash lanes and holds the hashes still to come out
    class hash_tracker;
        bit [31:0] seed;
        bit [31:0] lane_a;
        bit [31:0] lane_b;
        bit        on_lane_b;
        bit [63:0] pending[$];
        int        errors;

        function new();
            seed = SEED_RESET;
            lane_a = '0;
            lane_b = '0;
            on_lane_b = 1'b0;
            errors = 0;
        endfunction

        // Mix one whole word and fold it into a lane
        function bit [31:0] mix_into(bit [31:0] lane, bit [31:0] word);
            bit [31:0] k;
            k = word * MIX_MUL;
            k ^= k >> MIX_SHIFT;
            k = k * MIX_MUL;
            return (lane * MIX_MUL) ^ k;
        endfunction

        // Advance the lanes by one accepted input transaction
        function void take_word(hash_word_t w);
            bit [31:0] mask;
            if (w.first)
            begin
                lane_a = seed ^ {1'b0, w.len};
                lane_b = '0;
                on_lane_b = 1'b0;
            end
            if (w.nbytes >= 3'd4)
            begin
                if (on_lane_b)
                    lane_b = mix_into(lane_b, w.word);
                else
                    lane_a = mix_into(lane_a, w.word);
                on_lane_b = !on_lane_b;
            end
            else if (w.nbytes != 3'd0)
            begin
                mask = (32'h1 << (8 * w.nbytes)) - 32'h1;
                lane_b ^= w.word & mask;
                lane_b = lane_b * MIX_MUL;
            end
            if (w.last)
            begin
                // cross-lane finalization
                lane_a ^= lane_b >> FIN_SH1; lane_a = lane_a * MIX_MUL;
                lane_b ^= lane_a >> FIN_SH2; lane_b = lane_b * MIX_MUL;
                lane_a ^= lane_b >> FIN_SH3; lane_a = lane_a * MIX_MUL;
                lane_b ^= lane_a >> FIN_SH4; lane_b = lane_b * MIX_MUL;
                pending.push_back({lane_a, lane_b});
            end
        endfunction

        // Compare an emitted hash with the oldest one outstanding
        function void match_hash(bit [63:0] got);
            bit [63:0] want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected hash, expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending.pop_front();
                if (want != got)
                begin
                    $display("%0t: hash mismatch, expected %h, actual %h",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        seed_we = 1'b0;
    logic [31:0] hash_seed = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] data_word = '0;
    logic [2:0]  word_bytes = '0;
    logic        is_first = 1'b0;
    logic        is_last = 1'b0;
    logic [30:0] message_length = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] hash_value;

    hash_tracker tracker = new();
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          words_sent = 0;

    murmur_hash_64b_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .seed_we        (seed_we),
        .hash_seed      (hash_seed),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_word      (data_word),
        .word_bytes     (word_bytes),
        .is_first       (is_first),
        .is_last        (is_last),
        .message_length (message_length),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hash_value     (hash_value)
    );

    always #4 clk = ~clk;

    // Receiver: random stall, check every accepted hash
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.match_hash(hash_value);
    end

    function automatic hash_word_t make_word(bit [31:0] d, bit [2:0] n, bit f, bit l,
                                             bit [30:0] len);
        hash_word_t w;
        w.word = d;
        w.nbytes = n;
        w.first = f;
        w.last = l;
        w.len = len;
        return w;
    endfunction

    // fill: 0 random, 1 all zeros, 2 all ones
    function automatic bit [31:0] pick_data(int fill);
        if (fill == 1)
            return 32'h0000_0000;
        else if (fill == 2)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Offer one word, with random idle cycles ahead of it, until accepted
    task automatic send_word(input hash_word_t w);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        data_word      <= w.word;
        word_bytes     <= w.nbytes;
        is_first       <= w.first;
        is_last        <= w.last;
        message_length <= w.len;
        do
            @(posedge clk);
        while (in_stall);
        tracker.take_word(w);
        words_sent++;
    endtask

    // Whole words, then an optional 1..3 byte tail; empty message is one zero-byte word
    task automatic send_message(input int nwhole, input int tail, input bit [30:0] len,
                                input bit mark_last, input int fill);
        hash_word_t w;
        int nw;
        nw = nwhole + ((tail > 0 || nwhole == 0) ? 1 : 0);
        for (int i = 0; i < nw; i++)
        begin
            w.word = pick_data(fill);
            w.nbytes = (i < nwhole) ? 3'd4 : 3'(tail);
            w.first = (i == 0);
            w.last = mark_last && (i == nw - 1);
            w.len = len;
            send_word(w);
        end
    endtask

    // Sender pauses until every outstanding hash has come out
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
    endtask

    // Seed write while idle; allow trailing work on a non-last word to finish
    task automatic write_seed(input bit [31:0] value);
        wait_drained();
        repeat (16) @(posedge clk);
        @(negedge clk);
        seed_we   <= 1'b1;
        hash_seed <= value;
        @(negedge clk);
        seed_we   <= 1'b0;
        tracker.seed = value;
    endtask

    // Mostly well-formed messages with random content, some noise and cut-off messages
    task automatic run_random(input int n_words);
        int target;
        int nwhole;
        int tail;
        bit [30:0] len;
        target = words_sent + n_words;
        while (words_sent < target)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                nwhole = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                      : $urandom_range(0, 5);
                tail = $urandom_range(0, 3);
                len = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'(4 * nwhole + tail);
                send_message(nwhole, tail, len, $urandom_range(0, 19) != 0,
                             ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
            end
            else
                send_word(make_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom),
                                    1'($urandom), 31'($urandom)));
            if ($urandom_range(0, 49) == 0)
                wait_drained();
        end
    endtask

    // Timeout
    initial
    begin
        #(8 * 1_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: lanes at zero after reset, no first mark
        send_word(make_word($urandom, 3'd4, 1'b0, 1'b1, 31'($urandom)));
        // empty message, data extremes, each tail size, max length
        send_message(0, 0, 31'd0, 1'b1, 1);
        send_message(1, 0, 31'd4, 1'b1, 1);
        send_message(1, 0, 31'd4, 1'b1, 2);
        send_message(0, 1, 31'd1, 1'b1, 0);
        send_message(0, 2, 31'd2, 1'b1, 0);
        send_message(0, 3, 31'd3, 1'b1, 0);
        send_message(2, 3, 31'd11, 1'b1, 0);
        send_message(1, 0, 31'h7FFF_FFFF, 1'b1, 2);
        // byte counts above four act as whole words
        send_word(make_word($urandom, 3'd5, 1'b1, 1'b0, 31'd12));
        send_word(make_word($urandom, 3'd6, 1'b0, 1'b0, 31'd12));
        send_word(make_word($urandom, 3'd7, 1'b0, 1'b1, 31'd12));
        // short word ahead of whole words
        send_word(make_word($urandom, 3'd2, 1'b1, 1'b0, 31'd10));
        send_word(make_word($urandom, 3'd4, 1'b0, 1'b0, 31'd10));
        send_word(make_word($urandom, 3'd4, 1'b0, 1'b1, 31'd10));
        // empty word inside a message
        send_word(make_word($urandom, 3'd4, 1'b1, 1'b0, 31'd8));
        send_word(make_word($urandom, 3'd0, 1'b0, 1'b0, 31'd8));
        send_word(make_word($urandom, 3'd4, 1'b0, 1'b1, 31'd8));
        // continue from finalized lanes without a first mark
        send_word(make_word($urandom, 3'd3, 1'b0, 1'b1, 31'($urandom)));

        // Random phases: no idling, sender idle, receiver stall, both light
        write_seed(32'h0000_0000);
        idle_pct = 0;  stall_pct = 0;
        run_random(500);
        write_seed(32'hFFFF_FFFF);
        idle_pct = 51; stall_pct = 0;
        run_random(500);
        write_seed($urandom);
        idle_pct = 0;  stall_pct = 51;
        run_random(500);
        write_seed($urandom);
        idle_pct = 8;  stall_pct = 8;
        run_random(500);

        wait_drained();
        repeat (20) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("CHECK OK");
        else
        begin
            if (tracker.pending.size() != 0)
                $display("%0t: %0d hashes never arrived", $time, tracker.pending.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
